// ===== src/cip_pkg.sv =====
// Shared constants for the checked integer power unit.
// No dependencies; imported by checked_integer_power_unit and tb_top.
package cip_pkg;

    localparam int DATA_W = 64;              // port width of operands and result
    localparam int WIDTH  = 64;              // arithmetic width, 8..64
    localparam int HALF   = (WIDTH + 1) / 2; // multiplier operand width
    localparam int OPW    = 2 * HALF;        // padded magnitude width
    localparam int PROD_W = 4 * HALF;        // full product width

    localparam logic [PROD_W-1:0] TOP_P = PROD_W'(1) << (WIDTH - 1);

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_NEG = 2'd2;

endpackage

// ===== src/checked_integer_power_unit.sv =====
// Checked integer power: right-to-left square-and-multiply with overflow check.
// Depends on cip_pkg.

// One transaction in, one out. The exponent is scanned from its low bit; each
// set bit costs one checked multiply of result by base, and each step that
// leaves higher bits costs one checked squaring. Every multiply runs on one
// shared HALF x HALF magnitude multiplier as four partial products plus a
// final accumulate and limit compare. A zero exponent needs no multiply, and
// a negative one goes straight from idle to the done state. in_stall is high
// for the whole computation. A finished result sits in the output register
// and the next operands are taken while it waits. Status: ST_OK, ST_OVF (a
// multiply overflowed) or ST_NEG (negative exponent); power is 0 unless
// status is ST_OK.
module checked_integer_power_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cip_pkg::DATA_W-1:0]  base,
    input  logic [cip_pkg::DATA_W-1:0]  exponent,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cip_pkg::DATA_W-1:0]  power,
    output logic [1:0]                  status
);
    import cip_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [2:0] STEP_LAST = 3'd4;

    logic [1:0]        state_reg, state_next;
    logic [2:0]        step_reg, step_next;
    logic              op_sqr_reg, op_sqr_next;
    logic [WIDTH-1:0]  e_reg, e_next;
    logic              b_neg_reg, b_neg_next;
    logic [WIDTH-1:0]  b_mag_reg, b_mag_next;
    logic              acc_neg_reg, acc_neg_next;
    logic [WIDTH-1:0]  acc_mag_reg, acc_mag_next;
    logic [OPW-1:0]    pp_reg, pp_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] power_reg, power_next;
    logic [1:0]        status_reg, status_next;

    logic [WIDTH-1:0]  in_bits;
    logic [WIDTH-1:0]  op_a;
    logic [OPW-1:0]    a_w, b_w;
    logic [HALF-1:0]   mul_x, mul_y;
    logic [OPW-1:0]    mul_p;
    logic [PROD_W-1:0] add_term, prod_sum, lim;
    logic              mul_neg, mul_ovf, new_neg, out_free;
    logic [WIDTH-1:0]  new_mag, e_half, acc_bits;

    // shared multiplier datapath
    always_comb
    begin
        op_a  = op_sqr_reg ? b_mag_reg : acc_mag_reg;
        a_w   = OPW'(op_a);
        b_w   = OPW'(b_mag_reg);
        mul_x = step_reg[1] ? a_w[OPW-1:HALF] : a_w[HALF-1:0];
        mul_y = step_reg[0] ? b_w[OPW-1:HALF] : b_w[HALF-1:0];
        mul_p = OPW'(mul_x) * OPW'(mul_y);
        case (step_reg)
            3'd1:    add_term = PROD_W'(pp_reg);
            3'd2:    add_term = PROD_W'(pp_reg) << HALF;
            3'd3:    add_term = PROD_W'(pp_reg) << HALF;
            3'd4:    add_term = PROD_W'(pp_reg) << (2 * HALF);
            default: add_term = '0;
        endcase
        prod_sum = prod_reg + add_term;
        mul_neg  = !op_sqr_reg && (acc_neg_reg != b_neg_reg);
        lim      = mul_neg ? TOP_P : TOP_P - PROD_W'(1);
        mul_ovf  = prod_sum > lim;
        new_mag  = prod_sum[WIDTH-1:0];
        new_neg  = mul_neg && (new_mag != '0);
        e_half   = e_reg >> 1;
        acc_bits = acc_neg_reg ? (~acc_mag_reg + WIDTH'(1)) : acc_mag_reg;
        in_bits  = base[WIDTH-1:0];
        out_free = !out_valid_reg || !out_stall;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        op_sqr_next     = op_sqr_reg;
        e_next          = e_reg;
        b_neg_next      = b_neg_reg;
        b_mag_next      = b_mag_reg;
        acc_neg_next    = acc_neg_reg;
        acc_mag_next    = acc_mag_reg;
        pp_next         = pp_reg;
        prod_next       = prod_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        power_next      = power_reg;
        status_next     = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    b_neg_next   = in_bits[WIDTH-1];
                    b_mag_next   = in_bits[WIDTH-1] ? (~in_bits + WIDTH'(1)) : in_bits;
                    e_next       = exponent[WIDTH-1:0];
                    acc_neg_next = 1'b0;
                    acc_mag_next = WIDTH'(1);
                    if (exponent[WIDTH-1])
                    begin
                        res_status_next = ST_NEG;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                step_next = '0;
                if (e_reg == '0)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else if (e_reg[0])
                begin
                    op_sqr_next = 1'b0;
                    state_next  = S_MUL;
                end
                else
                begin
                    e_next = e_half;
                    if (e_half == '0)
                    begin
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        op_sqr_next = 1'b1;
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                pp_next   = mul_p;
                prod_next = (step_reg == '0) ? '0 : prod_sum;
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_LAST)
                begin
                    if (mul_ovf)
                    begin
                        res_status_next = ST_OVF;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        if (op_sqr_reg)
                        begin
                            b_mag_next = new_mag;
                            b_neg_next = new_neg;
                        end
                        else
                        begin
                            acc_mag_next = new_mag;
                            acc_neg_next = new_neg;
                            e_next[0]    = 1'b0;
                        end
                        state_next = S_SCAN;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    power_next     = (res_status_reg == ST_OK) ?
                                     DATA_W'($signed(acc_bits)) : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_sqr_reg     <= op_sqr_next;
        e_reg          <= e_next;
        b_neg_reg      <= b_neg_next;
        b_mag_reg      <= b_mag_next;
        acc_neg_reg    <= acc_neg_next;
        acc_mag_reg    <= acc_mag_next;
        pp_reg         <= pp_next;
        prod_reg       <= prod_next;
        res_status_reg <= res_status_next;
        power_reg      <= power_next;
        status_reg     <= status_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign power     = power_reg;
    assign status    = status_reg;

`ifndef ASSERT_OFF
    // a new result is only loaded from the done state
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside done state");

    // error results carry a zero power
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (power_reg == '0))
        else $error("nonzero power with error status");

    // multiply step counter never runs past the final accumulate
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (step_reg <= STEP_LAST))
        else $error("multiply step out of range");

    // after the last step the sequencer leaves the multiply state
    a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL) && (step_reg == STEP_LAST)) |=> (state_reg != S_MUL))
        else $error("multiply did not finish");
`endif

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for checked_integer_power_unit.
// Drives base/exponent transactions with random gaps and stalls, predicts each
// result in-line and compares power and status. Depends on cip_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

    import cip_pkg::*;

    localparam int          W        = cip_pkg::WIDTH;
    localparam logic [63:0] WMASK    = {64{1'b1}} >> (64 - W);
    localparam logic [63:0] WTOP     = 64'd1 << (W - 1);
    localparam logic [63:0] S64_MAX  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] NEG_ONE  = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] NEG_TWO  = 64'hffff_ffff_ffff_fffe;
    localparam int          N_RANDOM = 440;
    localparam int          DRAIN_B  = 150;   // second drain point, mid random part
    localparam int          HOLD_AT  = 300;   // long receiver hold-off starts here
    localparam int          HOLD_LEN = 1500;
    localparam int          TAIL     = 800;

    typedef struct {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] exponent;
    } operand_t;

    typedef struct {
        logic [DATA_W-1:0] power;
        logic [1:0]        status;
    } power_res_t;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } signmag_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [DATA_W-1:0] base      = '0;
    logic [DATA_W-1:0] exponent  = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] power;
    logic [1:0]        status;

    operand_t   operand_q[$];
    power_res_t want_power_q[$];
    int         sent_cnt     = 0;
    int         results_seen = 0;
    int         err_cnt      = 0;
    int         directed_cnt = 0;
    int         total_cnt    = 0;
    int         gap_left     = 0;
    int         stall_left   = 0;
    bit         tx_burst     = 1'b0;
    bit         rx_burst     = 1'b0;
    logic       rx_hold      = 1'b0;

    checked_integer_power_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .base      (base),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .power     (power),
        .status    (status)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic signmag_t split_sign(input logic [63:0] bits);
        signmag_t v;
        bits  = bits & WMASK;
        v.neg = (bits & WTOP) != 0;
        v.mag = v.neg ? ((~bits + 64'd1) & WMASK) : bits;
        if (v.neg && v.mag == 0)
            v.mag = WTOP;
        return v;
    endfunction

    function automatic logic [63:0] join_sign(input signmag_t v);
        logic [63:0] bits;
        bits = (v.neg ? (~v.mag + 64'd1) : v.mag) & WMASK;
        if ((bits & WTOP) != 0)
            bits = bits | ~WMASK;
        return bits;
    endfunction

    // Signed W-bit multiply on magnitudes; returns 0 when the product overflows.
    function automatic logic mul_in_range(input signmag_t a, input signmag_t b,
                                          output signmag_t p);
        logic         neg;
        logic [127:0] full;
        logic [127:0] lim;
        neg  = a.neg != b.neg;
        full = {64'd0, a.mag} * {64'd0, b.mag};
        lim  = neg ? {64'd0, WTOP} : {64'd0, WTOP - 64'd1};
        p    = '0;
        if (full > lim)
            return 1'b0;
        p.mag = full[63:0];
        p.neg = neg && p.mag != 0;
        return 1'b1;
    endfunction

    function automatic power_res_t predict_power(input logic [63:0] b_in,
                                                 input logic [63:0] e_in);
        power_res_t r;
        signmag_t   b;
        signmag_t   acc;
        logic [63:0] e;
        b = split_sign(b_in);
        e = e_in & WMASK;
        r.power  = '0;
        r.status = ST_OVF;
        if ((e & WTOP) != 0)
        begin
            r.status = ST_NEG;
            return r;
        end
        acc.neg = 1'b0;
        acc.mag = 64'd1;
        while (e != 0)
        begin
            if (e[0])
            begin
                if (!mul_in_range(acc, b, acc))
                    return r;
            end
            e = e >> 1;
            if (e == 0)
                break;
            // a squaring overflow counts even when a later multiply never uses it
            if (!mul_in_range(b, b, b))
                return r;
        end
        r.power  = join_sign(acc);
        r.status = ST_OK;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void push_op(input logic [63:0] b, input logic [63:0] e);
        operand_t op;
        op.base     = b;
        op.exponent = e;
        operand_q.push_back(op);
    endfunction

    function automatic operand_t rand_operands();
        operand_t    op;
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        logic [63:0] mag;
        pick        = $urandom_range(0, 99);
        op.base     = {$urandom, $urandom};
        op.exponent = {$urandom, $urandom};
        if (pick < 30)
        begin
            // base of a given bit length, exponent around the overflow boundary
            len = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(1, 63);
            mag = (op.base & ((64'd1 << len) - 64'd1)) | (64'd1 << (len - 1));
            op.base     = $urandom_range(0, 1) ? -mag : mag;
            op.exponent = 64'($urandom_range(0, 63 / len + 2));
        end
        else if (pick < 45)
        begin
            // -1, 0 or 1 never overflows: long scans over the whole exponent
            k = $urandom_range(0, 2);
            op.base         = (k == 0) ? 64'd0 : (k == 1) ? 64'd1 : NEG_ONE;
            op.exponent[63] = 1'b0;
            op.exponent     = op.exponent >> $urandom_range(0, 60);
        end
        else if (pick < 55)
        begin
            len = $urandom_range(0, 63);
            mag = 64'd1 << len;
            op.base     = $urandom_range(0, 1) ? -mag : mag;
            op.exponent = 64'($urandom_range(0, 64 / ((len == 0) ? 1 : len) + 1));
        end
        else if (pick < 70)
            op.exponent[63] = 1'b1;
        else if (pick < 80)
            op.exponent = 64'($urandom_range(0, 3));
        return op;
    endfunction

    // ---------------------------------------------------------------- driver

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        operand_t op;
        logic     fire;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            base     <= '0;
            exponent <= '0;
            gap_left = 0;
        end
        else
        begin
            fire = in_valid && !in_stall;
            if (fire)
            begin
                want_power_q.push_back(predict_power(base, exponent));
                sent_cnt++;
                gap_left = tx_burst ? 0 : $urandom_range(0, 6);
                if (sent_cnt % 40 == 0)
                    tx_burst = ($urandom_range(0, 3) == 0);
            end
            if (!in_valid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if ((sent_cnt == directed_cnt || sent_cnt == DRAIN_B)
                         && want_power_q.size() != 0)
                    in_valid <= 1'b0;   // let the block drain completely
                else if (operand_q.size() != 0)
                begin
                    op = operand_q.pop_front();
                    base     <= op.base;
                    exponent <= op.exponent;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        power_res_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (want_power_q.size() == 0)
                begin
                    $error("unexpected transaction: power %h status %0d", power, status);
                    err_cnt++;
                end
                else
                begin
                    want = want_power_q.pop_front();
                    if (power !== want.power)
                    begin
                        $error("power: expected %h, got %h", want.power, power);
                        err_cnt++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        err_cnt++;
                    end
                end
                results_seen++;
                stall_left = rx_burst ? 0 : $urandom_range(0, 6);
                if (results_seen % 37 == 0)
                    rx_burst = ($urandom_range(0, 3) == 0);
            end
            else if (out_valid && stall_left > 0)
                stall_left--;
            out_stall <= rx_hold || (stall_left > 0);
        end
    end

    // long hold-off so the result register fills and in_stall backs up
    initial
    begin
        wait (sent_cnt >= HOLD_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #30_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        // zero exponent, including zero base
        push_op(64'd0,   64'd0);
        push_op(S64_MIN, 64'd0);
        push_op(S64_MAX, 64'd0);
        // zero base, short and full-length scans
        push_op(64'd0,   64'd3);
        push_op(64'd0,   S64_MAX);
        // unit bases over the longest exponent
        push_op(64'd1,   S64_MAX);
        push_op(NEG_ONE, S64_MAX);
        push_op(NEG_ONE, S64_MAX - 64'd1);
        // overflow boundaries
        push_op(64'd2,   64'd62);
        push_op(64'd2,   64'd63);
        push_op(NEG_TWO, 64'd63);
        push_op(NEG_TWO, 64'd64);
        push_op(S64_MAX, 64'd1);
        push_op(S64_MAX, 64'd2);
        push_op(S64_MIN, 64'd1);
        push_op(S64_MIN, 64'd2);
        push_op(64'd3,   64'd39);
        push_op(64'd3,   64'd40);
        push_op(-64'd3,  64'd39);
        // squaring overflows before the multiply that would use it
        push_op(64'd1 << 32, 64'd2);
        push_op(64'd1 << 32, 64'd1);
        push_op(64'd1 << 31, 64'd2);
        // negative exponents
        push_op(64'd5,   NEG_ONE);
        push_op(S64_MAX, S64_MIN);
        directed_cnt = operand_q.size();
        for (int i = 0; i < N_RANDOM; i++)
            operand_q.push_back(rand_operands());
        total_cnt = operand_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (sent_cnt == total_cnt);
        wait (want_power_q.size() == 0);
        repeat (TAIL) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
